FILE: sv/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

	localparam int COEF_W = 39;
	localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
	localparam int CW = 41;
	localparam int NW = 58;
	localparam int DVD_W = 72;
	localparam int DEN_W = 40;
	localparam int QM_W = 63;
	localparam int SW = 66;
	localparam logic [SW-1:0] U_HIGH = SW'(589824);
	localparam logic [SW-1:0] U_LOW = SW'(65536);
	localparam logic [7:0] PERIOD_SCALE = 8'd200;

	typedef enum logic [1:0] {
		CFG_KP,
		CFG_KI,
		CFG_KD,
		CFG_T
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CL_NONE = 2'd0,
		CL_HIGH = 2'd1,
		CL_LOW  = 2'd2
	} clamp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KP,
		ST_TT,
		ST_KIH,
		ST_KIL,
		ST_KISUM,
		ST_COEF,
		ST_A_LO,
		ST_A_HI,
		ST_B_LO,
		ST_B_HI,
		ST_G_LO,
		ST_G_HI,
		ST_DEN,
		ST_DIVSTART,
		ST_DIV,
		ST_ACC,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: sv/incremental_pid_controller.sv
`default_nettype none

// Incremental PID controller, one control step per input transfer.
// The slave stream carries measured_temp and setpoint; each accepted transfer
// yields exactly one master transfer with control_value, error_value and the
// clamp status in tuser. Gains and the sample period are written through the
// cfg channel, which is always ready and must only be used while the block
// is idle.
// A sample passes from its accepted transfer through the coefficient and
// error products on one shared 32x32 multiplier, the bit-serial divider
// (one quotient bit per cycle over a 72-bit dividend), the accumulator
// update and the output clamp. s_tready is high only while no sample is
// being worked on, so the next sample is accepted only once the last
// result has been loaded into the output register.
// The result sits in an output register; the next sample may be accepted
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds that result internally and stays not ready.
// Reset restores the default gains and clears the accumulator, the error
// history and the output valid.
module incremental_pid_controller #(
	parameter int ACC_WIDTH = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [14:0] measured_temp, [29:15] setpoint, [31:30] zero
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [19:0] control_value, [35:20] error_value, [39:36] zero
	output logic [39:0]      m_tdata,
	// [1:0] clamp_status
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire ipid_pkg::cfg_idx_t cfg_index,
	input  wire logic [31:0] cfg_data
);
	import ipid_pkg::*;

	state_t state_q, state_d;

	logic [31:0] kp_q, ki_q, kd_q, tp_q;
	logic [15:0] e_q, e1_q, e2_q;
	logic [ACC_WIDTH-1:0] u_q;

	logic [63:0] prod_s1;
	logic        pneg_s1, phi_s1;

	logic [COEF_W-1:0] p2_q, kit_q;
	logic [15:0]       ttl_q;
	logic [63:0]       kih_q;
	logic [CW-1:0]     alpha_q, beta_q;
	logic [NW-1:0]     n_q;
	logic              neg_q;

	logic        mv_q;
	logic [19:0] mcv_q;
	logic [15:0] merr_q;
	clamp_t      mst_q;

	logic [31:0]   t_eff;
	logic [15:0]   e_d;
	logic [31:0]   mul_a, mul_b;
	logic          mul_neg, term_op, term_hi, acc_en, div_start, div_done;
	logic [CW-1:0] coef_cur, cmag;
	logic [15:0]   err_cur, emag;
	logic [COEF_W-1:0] p2_d, kit_d;
	logic [63:0]   kit_sum;
	logic [41:0]   cmax42, cmin42, alpha_w, alpha_sat, beta_w, beta_sat;
	logic [NW-1:0] term, n_d, nmag;
	logic [DVD_W-1:0] dividend, quo;
	logic          huge;
	logic [SW-1:0] qm, us, sum, umax, umin, u_sel, uc;
	logic [ACC_WIDTH-1:0] u_d;
	logic [19:0]   cv_d;
	clamp_t        st_d;
	logic          out_load, in_xfer;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_load = (state_q == ST_FIN) && (!mv_q || m_tready);
	assign t_eff = (tp_q == 32'd0) ? 32'd1 : tp_q;
	assign e_d = {s_tdata[29], s_tdata[29:15]} - {s_tdata[14], s_tdata[14:0]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_KP;
			ST_KP:       state_d = ST_TT;
			ST_TT:       state_d = ST_KIH;
			ST_KIH:      state_d = ST_KIL;
			ST_KIL:      state_d = ST_KISUM;
			ST_KISUM:    state_d = ST_COEF;
			ST_COEF:     state_d = ST_A_LO;
			ST_A_LO:     state_d = ST_A_HI;
			ST_A_HI:     state_d = ST_B_LO;
			ST_B_LO:     state_d = ST_B_HI;
			ST_B_HI:     state_d = ST_G_LO;
			ST_G_LO:     state_d = ST_G_HI;
			ST_G_HI:     state_d = ST_DEN;
			ST_DEN:      state_d = ST_DIVSTART;
			ST_DIVSTART: state_d = ST_DIV;
			ST_DIV:      if (div_done) state_d = ST_ACC;
			ST_ACC:      state_d = ST_FIN;
			ST_FIN:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Each state that drives the multiplier issues one product and, for the
	// error terms, folds in the product issued by the state before.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		coef_cur = alpha_q;
		err_cur = e_q;
		term_op = 1'b0;
		term_hi = 1'b0;
		acc_en = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_KP: begin
				mul_a = t_eff;
				mul_b = kp_q;
			end
			ST_TT: begin
				mul_a = t_eff;
				mul_b = t_eff;
			end
			ST_KIH: begin
				mul_a = ki_q;
				mul_b = prod_s1[63:32];
			end
			ST_KIL: begin
				mul_a = ki_q;
				mul_b = {16'b0, ttl_q};
			end
			ST_A_LO: begin
				term_op = 1'b1;
			end
			ST_A_HI: begin
				term_op = 1'b1;
				term_hi = 1'b1;
				acc_en = 1'b1;
			end
			ST_B_LO: begin
				coef_cur = beta_q;
				err_cur = e1_q;
				term_op = 1'b1;
				acc_en = 1'b1;
			end
			ST_B_HI: begin
				coef_cur = beta_q;
				err_cur = e1_q;
				term_op = 1'b1;
				term_hi = 1'b1;
				acc_en = 1'b1;
			end
			ST_G_LO: begin
				coef_cur = {{(CW-33){1'b0}}, kd_q, 1'b0};
				err_cur = e2_q;
				term_op = 1'b1;
				acc_en = 1'b1;
			end
			ST_G_HI: begin
				coef_cur = {{(CW-33){1'b0}}, kd_q, 1'b0};
				err_cur = e2_q;
				term_op = 1'b1;
				term_hi = 1'b1;
				acc_en = 1'b1;
			end
			ST_DEN: begin
				mul_a = t_eff;
				mul_b = {24'b0, PERIOD_SCALE};
				acc_en = 1'b1;
			end
			ST_DIVSTART: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
		cmag = coef_cur[CW-1] ? (~coef_cur + CW'(1)) : coef_cur;
		emag = err_cur[15] ? (~err_cur + 16'd1) : err_cur;
		mul_neg = coef_cur[CW-1] ^ err_cur[15];
		if (term_op) begin
			mul_a = term_hi ? {{(64-CW){1'b0}}, cmag[CW-1:32]} : cmag[31:0];
			mul_b = {16'b0, emag};
		end
	end

	always_comb begin
		p2_d = (|prod_s1[63:54]) ? COEF_MAX : prod_s1[53:15];
		kit_sum = kih_q + {16'b0, prod_s1[63:16]};
		kit_d = (|kit_sum[63:39]) ? COEF_MAX : kit_sum[38:0];
		cmax42 = {3'b0, COEF_MAX};
		cmin42 = ~cmax42 + 42'd1;
		alpha_w = {3'b0, p2_q} + {3'b0, kit_q} + {9'b0, kd_q, 1'b0};
		alpha_sat = (alpha_w > cmax42) ? cmax42 : alpha_w;
		beta_w = {3'b0, kit_q} - {8'b0, kd_q, 2'b0} - {3'b0, p2_q};
		priority if ($signed(beta_w) > $signed(cmax42)) beta_sat = cmax42;
		else if ($signed(beta_w) < $signed(cmin42)) beta_sat = cmin42;
		else beta_sat = beta_w;
		term = phi_s1 ? {prod_s1[NW-33:0], 32'b0} : prod_s1[NW-1:0];
		n_d = pneg_s1 ? (n_q - term) : (n_q + term);
		nmag = n_q[NW-1] ? (~n_q + NW'(1)) : n_q;
		dividend = {nmag[DVD_W-17:0], 16'b0};
	end

	always_comb begin
		huge = |quo[DVD_W-1:QM_W];
		qm = {{(SW-QM_W){1'b0}}, quo[QM_W-1:0]};
		us = {{(SW-ACC_WIDTH){u_q[ACC_WIDTH-1]}}, u_q};
		sum = neg_q ? (us - qm) : (us + qm);
		umax = (SW'(1) << (ACC_WIDTH - 1)) - SW'(1);
		umin = ~umax;
		if (neg_q) begin
			u_sel = (huge || ($signed(sum) < $signed(umin))) ? umin : sum;
		end else begin
			u_sel = (huge || ($signed(sum) > $signed(umax))) ? umax : sum;
		end
		u_d = u_sel[ACC_WIDTH-1:0];
	end

	always_comb begin
		uc = {{(SW-ACC_WIDTH){u_q[ACC_WIDTH-1]}}, u_q};
		priority if ($signed(uc) > $signed(U_HIGH)) begin
			cv_d = U_HIGH[19:0];
			st_d = CL_HIGH;
		end else if ($signed(uc) <= $signed(U_LOW)) begin
			cv_d = U_LOW[19:0];
			st_d = CL_LOW;
		end else begin
			cv_d = uc[19:0];
			st_d = CL_NONE;
		end
	end

	ipid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (prod_s1[DEN_W-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kp_q <= 32'd42598;
			ki_q <= 32'd7;
			kd_q <= 32'd0;
			tp_q <= 32'd65536;
			u_q <= '0;
			e1_q <= '0;
			e2_q <= '0;
			mv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KP: kp_q <= cfg_data;
					CFG_KI: ki_q <= cfg_data;
					CFG_KD: kd_q <= cfg_data;
					CFG_T:  tp_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_ACC) begin
				u_q <= u_d;
			end
			if (out_load) begin
				e2_q <= e1_q;
				e1_q <= e_q;
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {32'b0, mul_a} * {32'b0, mul_b};
		pneg_s1 <= mul_neg;
		phi_s1 <= term_hi;
		if (in_xfer) begin
			e_q <= e_d;
		end
		if (acc_en) begin
			n_q <= n_d;
		end
		unique case (state_q)
			ST_TT:       p2_q <= p2_d;
			ST_KIH:      ttl_q <= prod_s1[31:16];
			ST_KIL:      kih_q <= prod_s1;
			ST_KISUM:    kit_q <= kit_d;
			ST_COEF: begin
				alpha_q <= alpha_sat[CW-1:0];
				beta_q <= beta_sat[CW-1:0];
				n_q <= '0;
			end
			ST_DIVSTART: neg_q <= n_q[NW-1];
			default: begin
			end
		endcase
		if (out_load) begin
			mcv_q <= cv_d;
			merr_q <= e_q;
			mst_q <= st_d;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata = {4'b0, merr_q, mcv_q};
	assign m_tuser = mst_q;

endmodule

`default_nettype wire

FILE: sv/ipid_div.sv
`default_nettype none

module ipid_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ipid_pkg::DVD_W-1:0]  dividend,
	input  wire logic [ipid_pkg::DEN_W-1:0]  divisor,
	output logic                             done,
	output logic [ipid_pkg::DVD_W-1:0]       quotient
);
	import ipid_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DVD_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             fits;

	// One quotient bit per cycle; the dividend shifts out of the quotient register.
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff = rem_sh - {1'b0, den_q};
		fits = !diff[DEN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: bench/tb_incremental_pid_controller.sv
`timescale 1ns / 1ps

module tb_incremental_pid_controller;
	import ipid_pkg::*;

	localparam int ACC_W = 48;
	localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam longint COEF_SAT = 64'sd549755813887;
	localparam longint DRIVE_HI = 64'sd589824;
	localparam longint DRIVE_LO = 64'sd65536;
	localparam logic [31:0] KP_RESET = 32'd42598;
	localparam logic [31:0] KI_RESET = 32'd7;
	localparam logic [31:0] KD_RESET = 32'd0;
	localparam logic [31:0] PERIOD_RESET = 32'd65536;
	localparam int SAMPLES_PER_PHASE = 150;
	localparam int PHASES = 13;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [19:0] control;
		logic signed [15:0] err;
		clamp_t status;
	} drive_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] cur_kp = KP_RESET;
	logic [31:0] cur_ki = KI_RESET;
	logic [31:0] cur_kd = KD_RESET;
	logic [31:0] cur_period = PERIOD_RESET;
	longint acc_prev = 0;
	longint err_d1 = 0;
	longint err_d2 = 0;

	drive_result_t pending_drives[$];
	int fail_count = 0;
	bit idle_en = 1'b1;
	int ready_hold = 0;

	incremental_pid_controller #(
		.ACC_WIDTH(ACC_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("[incremental_pid_controller] ERROR");
		$finish;
	end

	function automatic longint clip_coef(longint v);
		if (v > COEF_SAT) begin
			return COEF_SAT;
		end
		if (v < -COEF_SAT) begin
			return -COEF_SAT;
		end
		return v;
	endfunction

	function automatic drive_result_t next_drive(logic signed [14:0] meas, logic signed [14:0] sp);
		u64_t per, p2u, tt, kprod, magn, den, quot, rem, mag, room;
		longint e, p2, ki_term, d2, alpha, beta, n, u;
		bit huge;
		drive_result_t r;
		per = (cur_period == 32'd0) ? u64_t'(1) : u64_t'(cur_period);
		e = longint'(sp) - longint'(meas);
		p2u = (per * 64'(cur_kp)) >> 15;
		p2 = (p2u > u64_t'(COEF_SAT)) ? COEF_SAT : longint'(p2u);
		tt = (per * per) >> 16;
		kprod = 64'(cur_ki) * (tt >> 16) + ((64'(cur_ki) * (tt & 64'hFFFF)) >> 16);
		ki_term = (kprod > u64_t'(COEF_SAT)) ? COEF_SAT : longint'(kprod);
		d2 = longint'(64'(cur_kd) << 1);
		alpha = clip_coef(p2 + ki_term + d2);
		beta = clip_coef(ki_term - 2 * d2 - p2);
		n = alpha * e + beta * err_d1 + d2 * err_d2;
		magn = (n < 0) ? u64_t'(-n) : u64_t'(n);
		den = u64_t'(200) * per;
		quot = magn / den;
		rem = magn % den;
		huge = quot >= (u64_t'(1) << 47);
		mag = huge ? u64_t'(0) : (quot << 16) + ((rem << 16) / den);
		if (n >= 0) begin
			room = u64_t'(ACC_MAX - acc_prev);
			u = (huge || mag > room) ? ACC_MAX : acc_prev + longint'(mag);
		end else begin
			room = u64_t'(acc_prev - ACC_MIN);
			u = (huge || mag > room) ? ACC_MIN : acc_prev - longint'(mag);
		end
		acc_prev = u;
		err_d2 = err_d1;
		err_d1 = e;
		if (u > DRIVE_HI) begin
			r.control = DRIVE_HI[19:0];
			r.status = CL_HIGH;
		end else if (u <= DRIVE_LO) begin
			r.control = DRIVE_LO[19:0];
			r.status = CL_LOW;
		end else begin
			r.control = u[19:0];
			r.status = CL_NONE;
		end
		r.err = e[15:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(1, 5);
		end
		m_tready <= (ready_hold == 0);
	end

	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				$display("%0t: unexpected transfer, control_value actual %0d", $time,
					m_tdata[19:0]);
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				if (m_tdata[19:0] !== want.control) begin
					$display("%0t: control_value expected %0d actual %0d", $time,
						want.control, m_tdata[19:0]);
					fail_count++;
				end
				if (m_tdata[35:20] !== want.err) begin
					$display("%0t: error_value expected %0d actual %0d", $time,
						want.err, $signed(m_tdata[35:20]));
					fail_count++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: clamp_status expected %0d actual %0d", $time,
						want.status, m_tuser);
					fail_count++;
				end
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_KP: cur_kp = value;
			CFG_KI: cur_ki = value;
			CFG_KD: cur_kd = value;
			CFG_T: cur_period = value;
		endcase
	endtask

	task automatic write_gains(input logic [31:0] kp, ki, kd, per);
		write_reg(CFG_KP, kp);
		write_reg(CFG_KI, ki);
		write_reg(CFG_KD, kd);
		write_reg(CFG_T, per);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [14:0] meas, input logic signed [14:0] sp);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, sp, meas};
		do @(posedge clk); while (!s_tready);
		pending_drives.push_back(next_drive(meas, sp));
	endtask

	task automatic send_random_sample();
		logic signed [14:0] meas, sp;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			meas = 15'($urandom);
			sp = 15'($urandom);
		end else if (pick < 4) begin
			meas = 15'(int'($urandom_range(0, 17500)) - 4500);
			sp = 15'(int'($urandom_range(0, 17500)) - 4500);
		end else begin
			sp = 15'(int'($urandom_range(0, 17500)) - 4500);
			meas = 15'(int'(sp) - (int'($urandom_range(0, 2400)) - 1000));
		end
		send_sample(meas, sp);
	endtask

	function automatic logic [31:0] pick_word(input logic [31:0] typical_max);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, typical_max);
		endcase
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return $urandom_range(16384, 262144);
		endcase
	endfunction

	task automatic test_default_gains();
		send_sample(-15'sd4500, -15'sd4500);
		send_sample(15'sd12800, 15'sd13000);
	endtask

	// The drive is first brought back to exactly zero, then walked onto both clamp edges.
	task automatic test_clamp_boundaries();
		wait_idle();
		write_gains(32'd900, 32'd0, 32'd0, 32'd65536);
		send_sample(15'sd9267, 15'sd0);
		wait_idle();
		write_gains(32'd65536, 32'd0, 32'd0, 32'd65536);
		send_sample(15'sd9167, 15'sd0);
		send_sample(15'sd8367, 15'sd0);
		send_sample(15'sd8366, 15'sd0);
		send_sample(15'sd9166, 15'sd0);
		send_sample(15'sd9167, 15'sd0);
	endtask

	task automatic test_field_extremes();
		wait_idle();
		write_gains(KP_RESET, KI_RESET, KD_RESET, PERIOD_RESET);
		send_sample(-15'sd4500, 15'sd13000);
		send_sample(15'sd13000, -15'sd4500);
		send_sample(15'sd13000, 15'sd13000);
		send_sample(-15'sd4500, -15'sd4500);
		send_sample(-15'sd16384, 15'sd16383);
		send_sample(15'sd16383, -15'sd16384);
	endtask

	task automatic test_coef_saturation();
		wait_idle();
		write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(-15'sd4500, 15'sd13000);
		send_sample(15'sd13000, -15'sd4500);
		send_sample(15'sd0, 15'sd0);
		send_sample(15'sd0, 15'sd100);
	endtask

	task automatic test_acc_saturation();
		wait_idle();
		write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		send_sample(-15'sd4500, 15'sd13000);
		send_sample(-15'sd4500, 15'sd13000);
		send_sample(15'sd13000, -15'sd4500);
		send_sample(15'sd13000, -15'sd4500);
		send_sample(15'sd13000, -15'sd4500);
		send_sample(15'sd0, 15'sd0);
	endtask

	task automatic test_zero_period();
		wait_idle();
		write_gains(KP_RESET, KI_RESET, 32'd1000, 32'd0);
		send_sample(15'sd1000, 15'sd1100);
		send_sample(15'sd1100, 15'sd1000);
		send_sample(15'sd0, 15'sd300);
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			if (ph == PHASES - 1) begin
				idle_en = 1'b0;
			end
			if (ph == 0) begin
				write_gains(KP_RESET, KI_RESET, KD_RESET, PERIOD_RESET);
			end else if (ph % 2 == 1) begin
				write_gains($urandom_range(0, 131072), $urandom_range(0, 64),
					$urandom_range(0, 20000), $urandom_range(16384, 131072));
			end else begin
				write_gains(pick_word(32'd262144), pick_word(32'd4096), pick_word(32'd65536),
					pick_period());
			end
			for (int k = 0; k < SAMPLES_PER_PHASE; k++) begin
				if ($urandom_range(0, 99) == 0) begin
					wait_idle();
				end
				send_random_sample();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 32'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KP;
		cfg_data = 32'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_gains();
		test_clamp_boundaries();
		test_field_extremes();
		test_coef_saturation();
		test_acc_saturation();
		test_zero_period();
		test_random_traffic();
		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_drives.size() == 0) begin
			$display("[incremental_pid_controller] OK");
		end else begin
			$display("[incremental_pid_controller] ERROR");
		end
		$finish;
	end

endmodule
